// ----- hw/rtl/range_weighted_square_count_query_macros.svh -----
// Assertion macros for the range weighted square count query block.
// Included by the files that carry concurrent assertions; needs no package.
`ifndef RANGE_WEIGHTED_SQUARE_COUNT_QUERY_MACROS_SVH
`define RANGE_WEIGHTED_SQUARE_COUNT_QUERY_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is high.
`define RWSQ_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rwsq assertion failed");
// Next-cycle implication, disabled while reset is high.
`define RWSQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rwsq assertion failed");
`else
`define RWSQ_ASSERT_IMPL(label, clk, rst, ante, cons)
`define RWSQ_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ----- hw/rtl/rwsq_pkg.sv -----
// Shared types and constants for the range weighted square count query block.
// No dependencies; the interfaces, rwsq_ctrl, rwsq_dp and the top level import this package.
package rwsq_pkg;

  localparam int ARRAY_DEPTH_DEF = 1024;
  localparam int VALUE_RANGE_DEF = 1024;

  localparam int IDX_W  = 10;  // index fields of a request
  localparam int ELEM_W = 10;  // element value width
  localparam int CNT_W  = 11;  // per-value occurrence count
  localparam int SQ_W   = 2 * CNT_W;
  localparam int RUN_W  = 31;  // running sum, wraps modulo 2**31
  localparam int ANS_W  = 30;
  localparam int CMP_W  = 17;  // wide enough to hold any depth parameter below 2**17

  localparam logic ACT_LOAD   = 1'b0;
  localparam logic ACT_QUERY  = 1'b1;
  localparam logic STS_OK     = 1'b0;
  localparam logic STS_REJECT = 1'b1;

  typedef enum logic [1:0] {
    MV_GROW_R   = 2'd0,
    MV_GROW_L   = 2'd1,
    MV_SHRINK_R = 2'd2,
    MV_SHRINK_L = 2'd3
  } move_t;

  typedef struct packed {
    logic  capture;
    logic  clear_we;
    logic  elem_wr;
    logic  elem_rd_load;
    logic  move_go;
    move_t move;
    logic  cnt_rd;
    logic  val_from_req;
    logic  cnt_upd;
    logic  grow;
    logic  mult;
    logic  accum;
    logic  res_load;
    logic  res_reject;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
    logic is_query;
    logic load_ok;
    logic in_window;
    logic query_bad;
    logic need_grow_r;
    logic need_grow_l;
    logic need_shrink_r;
    logic need_shrink_l;
  } sts_t;

endpackage

// ----- hw/rtl/rwsq_req_if.sv -----
// Request channel: valid/ready handshake with load and query fields.
// Depends on rwsq_pkg for the field widths.
interface rwsq_req_if import rwsq_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             action;
  logic [IDX_W-1:0] load_index;
  logic [IDX_W-1:0] load_value;
  logic [IDX_W-1:0] range_left;
  logic [IDX_W-1:0] range_right;

  modport source (output valid, action, load_index, load_value, range_left, range_right,
                  input ready);
  modport sink (input valid, action, load_index, load_value, range_left, range_right,
                output ready);
endinterface

// ----- hw/rtl/rwsq_res_if.sv -----
// Result channel: valid/ready handshake with the answer and status fields.
// Depends on rwsq_pkg for the field widths.
interface rwsq_res_if import rwsq_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ANS_W-1:0] answer;
  logic             status;

  modport source (output valid, answer, status, input ready);
  modport sink (input valid, answer, status, output ready);
endinterface

// ----- hw/rtl/range_weighted_square_count_query.sv -----
// Range weighted square count query: top level. Uses rwsq_pkg, the channel
// interfaces, rwsq_ctrl and rwsq_dp. A query goes through decide, a plan, value, count,
// multiply and accumulate pass per one-index window move, and a closing plan that
// registers the result; a rejected query's result is registered in decide. One request
// at a time; a load inside the window runs value to accumulate for old, then new value.
// After reset a clearing pass zeroes each of the VALUE_RANGE counts; no request is taken.
`include "range_weighted_square_count_query_macros.svh"

// The block keeps a window [start, end) over the element array together with
// a table of how often each value occurs inside it, and the running sum of
// count squared times value over all values. A query walks the window ends
// one index at a time toward [range_left, range_right]: first growing the
// right end, then the left end, then shrinking the right end and finally the
// left end, so a count never goes below zero. Each step reads the element,
// reads its count, writes the new count, forms the change of count squared
// and multiplies it by the value, then adds it into the running sum.
//
// A load writes one element. When its index lies inside the window, the old
// value leaves the count table and the new one enters, so the running sum
// stays consistent. Loads produce no result. A query whose left bound exceeds
// its right bound, or whose right bound lies past the array, is rejected
// with status set and a zero answer, and the window stays where it was.
//
// Only one request is worked on at a time. A finished result sits in the
// output register until it is taken, and the next request is accepted in the
// cycle after the result has left.
module range_weighted_square_count_query import rwsq_pkg::*; #(
  parameter int ARRAY_DEPTH = ARRAY_DEPTH_DEF,
  parameter int VALUE_RANGE = VALUE_RANGE_DEF
) (
  input  logic clk,
  input  logic rst,
  rwsq_req_if.sink   req,
  rwsq_res_if.source res
);

  cmd_t cmd;
  sts_t sts;
  logic req_ready_w;
  logic res_valid_w;
  logic res_rejected;
  logic move_wanted;

  // The controller sees only status flags and the two handshake inputs and issues
  // commands; all storage and arithmetic lives in the datapath.
  rwsq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .sts       (sts),
    .req_valid (req.valid),
    .res_ready (res.ready),
    .cmd       (cmd),
    .req_ready (req_ready_w),
    .res_valid (res_valid_w)
  );

  rwsq_dp #(
    .ARRAY_DEPTH (ARRAY_DEPTH),
    .VALUE_RANGE (VALUE_RANGE)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .action      (req.action),
    .load_index  (req.load_index),
    .load_value  (req.load_value),
    .range_left  (req.range_left),
    .range_right (req.range_right),
    .answer      (res.answer),
    .status      (res.status)
  );

  assign req.ready = req_ready_w;
  assign res.valid = res_valid_w;

  // Helper terms for the checks below.
  assign res_rejected = res.valid && (res.status == STS_REJECT);
  assign move_wanted  = sts.need_grow_r || sts.need_grow_l ||
                        sts.need_shrink_r || sts.need_shrink_l;

  // A pending result blocks new requests.
  `RWSQ_ASSERT_IMPL(a_no_req_while_result, clk, rst, res.valid, !req.ready)
  // A rejected query always reports a zero answer.
  `RWSQ_ASSERT_IMPL(a_reject_zero, clk, rst, res_rejected, res.answer == '0)
  // The block is busy in the cycle after it takes a request.
  `RWSQ_ASSERT_NEXT(a_busy_after_accept, clk, rst, req.valid && req.ready, !req.ready)
  // A window move is only issued when the window still differs from the range.
  `RWSQ_ASSERT_IMPL(a_move_needed, clk, rst, cmd.move_go, move_wanted)

endmodule

// ----- hw/rtl/rwsq_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rwsq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hw/rtl/rwsq_ctrl.sv -----
// Controller state machine: sequences loads, window moves and results.
// Depends on rwsq_pkg for the command and status structs.
module rwsq_ctrl import rwsq_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  sts_t sts,
  input  logic req_valid,
  input  logic res_ready,
  output cmd_t cmd,
  output logic req_ready,
  output logic res_valid
);

  typedef enum logic [7:0] {
    S_CLEAR  = 8'b00000001,
    S_IDLE   = 8'b00000010,
    S_DECIDE = 8'b00000100,
    S_PLAN   = 8'b00001000,
    S_VALUE  = 8'b00010000,
    S_COUNT  = 8'b00100000,
    S_MULT   = 8'b01000000,
    S_ACCUM  = 8'b10000000
  } state_t;

  // S_RESULT is folded into a flag so the state vector stays one-hot over
  // the working states; the result wait is its own register below.
  typedef enum logic [1:0] {
    JOB_GROW     = 2'd0,
    JOB_SHRINK   = 2'd1,
    JOB_LOAD_OLD = 2'd2,
    JOB_LOAD_NEW = 2'd3
  } job_t;

  state_t state, state_next;
  job_t   job, job_next;
  logic   pending, pending_next;

  assign req_ready = (state == S_IDLE) && !pending;
  assign res_valid = pending;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      job     <= JOB_GROW;
      pending <= 1'b0;
    end else begin
      state   <= state_next;
      job     <= job_next;
      pending <= pending_next;
    end
  end

  always_comb begin
    cmd          = '0;
    state_next   = state;
    job_next     = job;
    pending_next = pending;
    if (pending && res_ready) begin
      pending_next = 1'b0;
    end
    unique case (state)
      S_CLEAR: begin
        cmd.clear_we = 1'b1;
        if (sts.clear_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (req_valid && req_ready) begin
          cmd.capture = 1'b1;
          state_next  = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (!sts.is_query) begin
          state_next = S_IDLE;
          if (sts.load_ok) begin
            if (sts.in_window) begin
              cmd.elem_rd_load = 1'b1;
              job_next         = JOB_LOAD_OLD;
              state_next       = S_VALUE;
            end else begin
              cmd.elem_wr = 1'b1;
            end
          end
        end else if (sts.query_bad) begin
          cmd.res_reject = 1'b1;
          pending_next   = 1'b1;
          state_next     = S_IDLE;
        end else begin
          state_next = S_PLAN;
        end
      end
      S_PLAN: begin
        state_next = S_VALUE;
        priority if (sts.need_grow_r) begin
          cmd.move_go = 1'b1;
          cmd.move    = MV_GROW_R;
          job_next    = JOB_GROW;
        end else if (sts.need_grow_l) begin
          cmd.move_go = 1'b1;
          cmd.move    = MV_GROW_L;
          job_next    = JOB_GROW;
        end else if (sts.need_shrink_r) begin
          cmd.move_go = 1'b1;
          cmd.move    = MV_SHRINK_R;
          job_next    = JOB_SHRINK;
        end else if (sts.need_shrink_l) begin
          cmd.move_go = 1'b1;
          cmd.move    = MV_SHRINK_L;
          job_next    = JOB_SHRINK;
        end else begin
          cmd.res_load = 1'b1;
          pending_next = 1'b1;
          state_next   = S_IDLE;
        end
      end
      S_VALUE: begin
        cmd.cnt_rd       = 1'b1;
        cmd.val_from_req = (job == JOB_LOAD_NEW);
        cmd.elem_wr      = (job == JOB_LOAD_OLD);
        state_next       = S_COUNT;
      end
      S_COUNT: begin
        cmd.cnt_upd = 1'b1;
        cmd.grow    = (job == JOB_GROW) || (job == JOB_LOAD_NEW);
        state_next  = S_MULT;
      end
      S_MULT: begin
        cmd.mult   = 1'b1;
        state_next = S_ACCUM;
      end
      S_ACCUM: begin
        cmd.accum = 1'b1;
        unique case (job)
          JOB_LOAD_OLD: begin
            job_next   = JOB_LOAD_NEW;
            state_next = S_VALUE;
          end
          JOB_LOAD_NEW: state_next = S_IDLE;
          JOB_GROW, JOB_SHRINK: state_next = S_PLAN;
        endcase
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ----- hw/rtl/rwsq_dp.sv -----
// Datapath: element and count memories, window pointers and the running sum.
// Depends on rwsq_pkg and rwsq_ram.
module rwsq_dp import rwsq_pkg::*; #(
  parameter int ARRAY_DEPTH = ARRAY_DEPTH_DEF,
  parameter int VALUE_RANGE = VALUE_RANGE_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  cmd_t             cmd,
  output sts_t             sts,
  input  logic             action,
  input  logic [IDX_W-1:0] load_index,
  input  logic [IDX_W-1:0] load_value,
  input  logic [IDX_W-1:0] range_left,
  input  logic [IDX_W-1:0] range_right,
  output logic [ANS_W-1:0] answer,
  output logic             status
);

  localparam int AW = (ARRAY_DEPTH > 1) ? $clog2(ARRAY_DEPTH) : 1;
  localparam int PW = AW + 1;
  localparam int VW = (VALUE_RANGE > 1) ? $clog2(VALUE_RANGE) : 1;

  // Captured request.
  logic             req_action;
  logic [IDX_W-1:0] req_idx, req_val, req_left, req_right;

  // Window [win_start, win_end) and running sum.
  logic [PW-1:0]    win_start, win_end;
  logic [RUN_W-1:0] running;
  logic [VW-1:0]    clr_addr;

  // Per-adjust pipeline registers.
  logic [ELEM_W-1:0] val_q;
  logic              val_ok, adj_ok;
  logic [SQ_W-1:0]   sq_old, sq_new;
  logic [RUN_W-1:0]  prod;

  logic [ELEM_W-1:0] elem_rdata, val_sel;
  logic [CNT_W-1:0]  cnt_rdata, cnt_new;
  logic [PW-1:0]     mv_ptr;
  logic [AW-1:0]     elem_raddr;
  logic [VW-1:0]     cnt_waddr;
  logic [CNT_W-1:0]  cnt_wdata;
  logic [RUN_W-1:0]  diff, prod_full;

  // Status toward the controller.
  always_comb begin
    sts.clear_last    = (clr_addr == VW'(VALUE_RANGE - 1));
    sts.is_query      = (req_action == ACT_QUERY);
    sts.load_ok       = (CMP_W'(req_idx) < CMP_W'(ARRAY_DEPTH)) &&
                        (CMP_W'(req_val) < CMP_W'(VALUE_RANGE));
    sts.in_window     = (CMP_W'(req_idx) >= CMP_W'(win_start)) &&
                        (CMP_W'(req_idx) < CMP_W'(win_end));
    sts.query_bad     = (req_left > req_right) ||
                        (CMP_W'(req_right) >= CMP_W'(ARRAY_DEPTH));
    sts.need_grow_r   = CMP_W'(win_end) <= CMP_W'(req_right);
    sts.need_grow_l   = CMP_W'(win_start) > CMP_W'(req_left);
    sts.need_shrink_r = CMP_W'(win_end) > (CMP_W'(req_right) + CMP_W'(1));
    sts.need_shrink_l = CMP_W'(win_start) < CMP_W'(req_left);
  end

  // Element index touched by a window move.
  always_comb begin
    unique case (cmd.move)
      MV_GROW_R:   mv_ptr = win_end;
      MV_GROW_L:   mv_ptr = win_start - PW'(1);
      MV_SHRINK_R: mv_ptr = win_end - PW'(1);
      MV_SHRINK_L: mv_ptr = win_start;
    endcase
    elem_raddr = cmd.move_go ? mv_ptr[AW-1:0] : AW'(req_idx);
  end

  assign val_sel = cmd.val_from_req ? req_val : elem_rdata;

  // Count after one occurrence enters or leaves; never drops below zero.
  always_comb begin
    if (cmd.grow) begin
      cnt_new = cnt_rdata + CNT_W'(1);
    end else if (cnt_rdata != '0) begin
      cnt_new = cnt_rdata - CNT_W'(1);
    end else begin
      cnt_new = cnt_rdata;
    end
  end

  assign cnt_waddr = cmd.clear_we ? clr_addr : VW'(val_q);
  assign cnt_wdata = cmd.clear_we ? '0 : cnt_new;
  assign diff      = RUN_W'(sq_new) - RUN_W'(sq_old);
  assign prod_full = diff * RUN_W'(val_q);

  rwsq_ram #(.WIDTH(ELEM_W), .DEPTH(ARRAY_DEPTH)) u_elem_ram (
    .clk   (clk),
    .we    (cmd.elem_wr),
    .waddr (AW'(req_idx)),
    .wdata (req_val),
    .re    (cmd.elem_rd_load | cmd.move_go),
    .raddr (elem_raddr),
    .rdata (elem_rdata)
  );

  rwsq_ram #(.WIDTH(CNT_W), .DEPTH(VALUE_RANGE)) u_cnt_ram (
    .clk   (clk),
    .we    (cmd.clear_we | (cmd.cnt_upd & val_ok)),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .re    (cmd.cnt_rd),
    .raddr (VW'(val_sel)),
    .rdata (cnt_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      win_start <= '0;
      win_end   <= '0;
      running   <= '0;
      clr_addr  <= '0;
    end else begin
      if (cmd.clear_we) begin
        clr_addr <= clr_addr + VW'(1);
      end
      if (cmd.move_go) begin
        unique case (cmd.move)
          MV_GROW_R:   win_end   <= win_end + PW'(1);
          MV_GROW_L:   win_start <= win_start - PW'(1);
          MV_SHRINK_R: win_end   <= win_end - PW'(1);
          MV_SHRINK_L: win_start <= win_start + PW'(1);
        endcase
      end
      if (cmd.accum) begin
        running <= running + prod;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_action <= action;
      req_idx    <= load_index;
      req_val    <= load_value;
      req_left   <= range_left;
      req_right  <= range_right;
    end
    if (cmd.cnt_rd) begin
      val_q  <= val_sel;
      val_ok <= CMP_W'(val_sel) < CMP_W'(VALUE_RANGE);
    end
    if (cmd.cnt_upd) begin
      sq_old <= SQ_W'(cnt_rdata) * SQ_W'(cnt_rdata);
      sq_new <= SQ_W'(cnt_new) * SQ_W'(cnt_new);
      adj_ok <= val_ok;
    end
    if (cmd.mult) begin
      prod <= adj_ok ? prod_full : '0;
    end
    if (cmd.res_load) begin
      answer <= running[ANS_W-1:0];
      status <= STS_OK;
    end else if (cmd.res_reject) begin
      answer <= '0;
      status <= STS_REJECT;
    end
  end

endmodule

// ----- verif/tb_top.sv -----
// Self-checking testbench for range_weighted_square_count_query.
// Uses rwsq_pkg and the rwsq_req_if / rwsq_res_if channel interfaces from hw/rtl.
`timescale 1ns / 1ps

module tb_top;
  import rwsq_pkg::*;

  localparam int LIMIT_CYCLES = 2_000_000;
  localparam int RANDOM_ITEMS = 480;
  localparam int PHASE_LEN    = RANDOM_ITEMS / 3;
  localparam int TOP_BLOCK    = 64;
  localparam int TAIL_CYCLES  = 64;
  localparam int MAX_REPORTS  = 10;

  // One request as the host sends it, plus testbench-only pacing marks.
  typedef struct {
    logic             action;
    logic [IDX_W-1:0] load_index;
    logic [IDX_W-1:0] load_value;
    logic [IDX_W-1:0] range_left;
    logic [IDX_W-1:0] range_right;
    bit               drain;  // hold this request back until all answers are in
    int               phase;  // idling profile in force when it is sent
  } request_t;

  typedef struct {
    logic [ANS_W-1:0] answer;
    logic             status;
  } answer_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  always #5 clk = ~clk;

  rwsq_req_if req_ch ();
  rwsq_res_if res_ch ();

  range_weighted_square_count_query dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .res(res_ch)
  );

  request_t pending_requests[$];
  answer_t  expected_answers[$];
  request_t driven_req;

  // Shadow copy of the block's window state, updated as requests are accepted.
  logic [ELEM_W-1:0] elem_tbl  [ARRAY_DEPTH_DEF];
  logic [CNT_W-1:0]  count_tbl [VALUE_RANGE_DEF];
  logic [CNT_W-1:0]  win_lo;
  logic [CNT_W-1:0]  win_hi;
  logic [RUN_W-1:0]  window_sum;

  // Stimulus-side bookkeeping. The generator tracks which elements have been
  // written and where the window will be, so that no window move ever reads
  // an element that was never loaded.
  bit loaded [ARRAY_DEPTH_DEF];
  int gen_lo;
  int gen_hi;
  int gen_phase;
  bit gen_drain;

  // Pacing and progress. The counters shared between the driver and the
  // monitor are updated with nonblocking assignments so that each block sees
  // the values from before the clock edge.
  int       send_idle_pct;
  int       rcv_idle_pct;
  int       queries_accepted;
  int       results_taken;
  int       loads_sent;
  int       queries_sent;
  int       rejects_sent;
  int       mismatch_count;
  int       cycle_count;
  logic [ANS_W-1:0] max_answer;

  // One occurrence of value v enters or leaves the window; the running sum of
  // count squared times value is corrected by the change for that value.
  function automatic void bump_count(logic [ELEM_W-1:0] v, bit grow);
    longint unsigned c;
    longint unsigned sq_old;
    longint unsigned sq_new;
    longint unsigned sum;
    c = count_tbl[v];
    sq_old = c * c * longint'(v);
    if (grow) begin
      c = c + 1;
    end else if (c > 0) begin
      c = c - 1;
    end
    count_tbl[v] = c[CNT_W-1:0];
    c = count_tbl[v];
    sq_new = c * c * longint'(v);
    sum = longint'(window_sum) - sq_old + sq_new;
    window_sum = sum[RUN_W-1:0];
  endfunction

  function automatic void reset_window_model();
    for (int i = 0; i < VALUE_RANGE_DEF; i++) begin
      count_tbl[i] = '0;
    end
    for (int i = 0; i < ARRAY_DEPTH_DEF; i++) begin
      elem_tbl[i] = '0;
    end
    win_lo = '0;
    win_hi = '0;
    window_sum = '0;
  endfunction

  // Applies one accepted request to the shadow state and records the answer a
  // query must return. The window first grows at the right end, then the left
  // end, then shrinks at the right end and finally at the left end.
  function automatic void predict_window_sum(request_t r);
    logic [CNT_W-1:0] end_x;
    answer_t a;
    if (r.action == ACT_LOAD) begin
      if (r.load_index >= win_lo && r.load_index < win_hi) begin
        bump_count(elem_tbl[r.load_index], 1'b0);
        elem_tbl[r.load_index] = r.load_value;
        bump_count(r.load_value, 1'b1);
      end else begin
        elem_tbl[r.load_index] = r.load_value;
      end
      return;
    end
    if (r.range_left > r.range_right) begin
      a.answer = '0;
      a.status = STS_REJECT;
      expected_answers.push_back(a);
      return;
    end
    end_x = CNT_W'(r.range_right) + 1'b1;
    while (win_hi < end_x) begin
      bump_count(elem_tbl[win_hi], 1'b1);
      win_hi = win_hi + 1'b1;
    end
    while (win_lo > CNT_W'(r.range_left)) begin
      win_lo = win_lo - 1'b1;
      bump_count(elem_tbl[win_lo], 1'b1);
    end
    while (win_hi > end_x) begin
      win_hi = win_hi - 1'b1;
      bump_count(elem_tbl[win_hi], 1'b0);
    end
    while (win_lo < CNT_W'(r.range_left)) begin
      bump_count(elem_tbl[win_lo], 1'b0);
      win_lo = win_lo + 1'b1;
    end
    a.answer = window_sum[ANS_W-1:0];
    a.status = STS_OK;
    expected_answers.push_back(a);
  endfunction

  function automatic int clamp_index(int x);
    if (x < 0) begin
      return 0;
    end
    if (x > ARRAY_DEPTH_DEF - 1) begin
      return ARRAY_DEPTH_DEF - 1;
    end
    return x;
  endfunction

  function automatic void queue_request(request_t r);
    r.phase = gen_phase;
    r.drain = gen_drain;
    gen_drain = 1'b0;
    pending_requests.push_back(r);
  endfunction

  // The range fields of a load are ignored by the block, so they carry noise.
  function automatic void queue_load(int idx, int val);
    request_t r;
    r.action = ACT_LOAD;
    r.load_index = IDX_W'(idx);
    r.load_value = IDX_W'(val);
    r.range_left = IDX_W'($urandom);
    r.range_right = IDX_W'($urandom);
    loaded[idx] = 1'b1;
    queue_request(r);
  endfunction

  // Before a query goes out, every element its window moves will read on the
  // growing side is loaded; elements on the shrinking side are already inside
  // the window and therefore written.
  function automatic void queue_query(int left, int right);
    request_t r;
    if (left <= right) begin
      for (int i = gen_hi; i <= right; i++) begin
        if (!loaded[i]) begin
          queue_load(i, $urandom_range(0, 1023));
        end
      end
      for (int i = left; i < gen_lo; i++) begin
        if (!loaded[i]) begin
          queue_load(i, $urandom_range(0, 1023));
        end
      end
      gen_lo = left;
      gen_hi = right + 1;
    end
    r.action = ACT_QUERY;
    r.load_index = IDX_W'($urandom);
    r.load_value = IDX_W'($urandom);
    r.range_left = IDX_W'(left);
    r.range_right = IDX_W'(right);
    queue_request(r);
  endfunction

  // Driver: presents the oldest pending request, holds it until it is taken,
  // and idles at random. A request marked for draining waits until every
  // answer owed so far has been collected.
  always @(posedge clk) begin : driver
    bit       fire;
    bit       hold;
    int       outstanding;
    request_t driven;
    if (rst) begin
      req_ch.valid <= 1'b0;
      reset_window_model();
    end else begin
      fire = req_ch.valid && req_ch.ready;
      outstanding = queries_accepted - results_taken;
      if (fire) begin
        predict_window_sum(driven_req);
        if (driven_req.action == ACT_QUERY) begin
          queries_accepted <= queries_accepted + 1;
          outstanding = outstanding + 1;
          queries_sent++;
          if (driven_req.range_left > driven_req.range_right) begin
            rejects_sent++;
          end
        end else begin
          loads_sent++;
        end
      end
      if (!req_ch.valid || fire) begin
        hold = (pending_requests.size() == 0) || ($urandom_range(0, 99) < send_idle_pct);
        if (!hold && pending_requests[0].drain && outstanding != 0) begin
          hold = 1'b1;
        end
        if (hold) begin
          req_ch.valid <= 1'b0;
        end else begin
          driven = pending_requests.pop_front();
          driven_req = driven;
          req_ch.valid <= 1'b1;
          req_ch.action <= driven.action;
          req_ch.load_index <= driven.load_index;
          req_ch.load_value <= driven.load_value;
          req_ch.range_left <= driven.range_left;
          req_ch.range_right <= driven.range_right;
          case (driven.phase)
            0: begin
              send_idle_pct <= 7;
              rcv_idle_pct <= 70;
            end
            1: begin
              send_idle_pct <= 70;
              rcv_idle_pct <= 7;
            end
            default: begin
              send_idle_pct <= 0;
              rcv_idle_pct <= 0;
            end
          endcase
        end
      end
    end
  end

  // Monitor: takes answers with a randomly stalling ready and checks each one
  // against the oldest expectation, field by field.
  always @(posedge clk) begin : monitor
    answer_t exp_a;
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        results_taken <= results_taken + 1;
        if (expected_answers.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS) begin
            $display("unexpected answer %0d status %0b with nothing outstanding",
                     res_ch.answer, res_ch.status);
          end
        end else begin
          exp_a = expected_answers.pop_front();
          if (res_ch.answer !== exp_a.answer || res_ch.status !== exp_a.status) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS) begin
              $display("answer #%0d: expected %0d status %0b, got %0d status %0b",
                       results_taken, exp_a.answer, exp_a.status,
                       res_ch.answer, res_ch.status);
            end
          end
          if (res_ch.status == STS_OK && res_ch.answer > max_answer) begin
            max_answer <= res_ch.answer;
          end
        end
      end
      res_ch.ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
    end
  end

  always @(posedge clk) begin : watchdog
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d answers outstanding",
               cycle_count, expected_answers.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    int kind;
    int lo;
    int hi;
    int tmp;
    int idx;
    int val;
    int base;
    int queued;
    int phase_now;

    // Every input of the block is known from time zero.
    req_ch.valid = 1'b0;
    req_ch.action = ACT_LOAD;
    req_ch.load_index = '0;
    req_ch.load_value = '0;
    req_ch.range_left = '0;
    req_ch.range_right = '0;
    res_ch.ready = 1'b0;
    send_idle_pct = 7;
    rcv_idle_pct = 70;
    queries_accepted = 0;
    results_taken = 0;
    loads_sent = 0;
    queries_sent = 0;
    rejects_sent = 0;
    mismatch_count = 0;
    cycle_count = 0;
    max_answer = '0;
    for (int i = 0; i < ARRAY_DEPTH_DEF; i++) begin
      loaded[i] = 1'b0;
    end
    gen_lo = 0;
    gen_hi = 0;
    gen_phase = 0;
    gen_drain = 1'b0;

    // Directed part. Rejections come first, while the window is still empty,
    // both at the extreme bounds and with left just one past right.
    queue_query(1023, 0);
    queue_query(5, 4);
    queue_load(0, 0);
    queue_load(1, 1023);
    queue_load(2, 1023);
    queue_load(3, 1);
    // The top index, loaded while it lies outside the window.
    queue_load(1023, 512);
    queue_query(0, 0);
    queue_query(0, 3);
    // A load inside the window swaps one value for another in the count table.
    queue_load(2, 1);
    gen_drain = 1'b1;
    queue_query(0, 3);
    queue_query(1, 2);
    queue_query(3, 3);
    queue_query(0, 3);
    queue_load(0, 1023);
    queue_query(2, 1);
    queue_query(0, 3);
    // A query that leaves the window where it is.
    queue_query(0, 3);

    // Random part: mostly queries close to the current window, the way a host
    // running sorted queries would send them, plus loads, rejections and
    // occasional wider jumps. It runs until enough requests are queued.
    base = pending_requests.size();
    while (pending_requests.size() < base + RANDOM_ITEMS) begin
      queued = pending_requests.size() - base;
      phase_now = (queued < PHASE_LEN) ? 0 : (queued < 2 * PHASE_LEN) ? 1 : 2;
      if (phase_now != gen_phase || $urandom_range(0, 99) < 2) begin
        gen_drain = 1'b1;
      end
      gen_phase = phase_now;
      kind = $urandom_range(0, 99);
      if (kind < 35) begin
        if (gen_hi > gen_lo && $urandom_range(0, 1) == 1) begin
          idx = $urandom_range(gen_lo, gen_hi - 1);
        end else begin
          idx = $urandom_range(0, 1023);
        end
        tmp = $urandom_range(0, 9);
        if (tmp < 4) begin
          val = $urandom_range(0, 1023);
        end else if (tmp < 8) begin
          val = $urandom_range(0, 7);
        end else begin
          val = 1023 - int'($urandom_range(0, 3));
        end
        queue_load(idx, val);
      end else if (kind < 40) begin
        lo = $urandom_range(1, 1023);
        hi = $urandom_range(0, lo - 1);
        queue_query(lo, hi);
      end else if (kind < 95) begin
        lo = clamp_index(gen_lo + int'($urandom_range(0, 40)) - 20);
        hi = clamp_index(gen_hi - 1 + int'($urandom_range(0, 40)) - 20);
        if (lo > hi) begin
          tmp = lo;
          lo = hi;
          hi = tmp;
        end
        queue_query(lo, hi);
      end else begin
        lo = clamp_index(gen_lo + int'($urandom_range(0, 400)) - 200);
        hi = clamp_index(lo + int'($urandom_range(0, 60)));
        queue_query(lo, hi);
      end
    end

    // Top-value block: a run of elements at the window's left end is set to
    // the top value, so one value reaches a large count, then the window is
    // shrunk to the last index of the run and grown back.
    lo = gen_lo;
    if (lo > ARRAY_DEPTH_DEF - TOP_BLOCK) begin
      lo = ARRAY_DEPTH_DEF - TOP_BLOCK;
    end
    hi = lo + TOP_BLOCK - 1;
    for (int i = lo; i <= hi; i++) begin
      queue_load(i, 1023);
    end
    queue_query(lo, hi);
    queue_query(hi, hi);
    queue_query(lo, hi);
    queue_query(hi, lo);
    queue_load(hi, 0);
    queue_query(lo, hi);

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Wait until every request has been taken and every answer has come back.
    @(negedge clk);
    while (pending_requests.size() != 0 || req_ch.valid || expected_answers.size() != 0) begin
      @(negedge clk);
    end
    // A trailing in-window load may still be working; let it settle.
    repeat (TAIL_CYCLES) @(posedge clk);
    @(negedge clk);

    if (expected_answers.size() != 0) begin
      mismatch_count += expected_answers.size();
      $display("%0d expected answers never arrived", expected_answers.size());
    end

    $display("Sent %0d loads and %0d queries (%0d rejected) over %0d cycles.",
             loads_sent, queries_sent, rejects_sent, cycle_count);
    $display("Checked %0d answers, largest %0d; %0d mismatches.",
             results_taken, max_answer, mismatch_count);
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ----- range_weighted_square_count_query.f -----
+incdir+hw/rtl
hw/rtl/rwsq_pkg.sv
hw/rtl/rwsq_req_if.sv
hw/rtl/rwsq_res_if.sv
hw/rtl/rwsq_ram.sv
hw/rtl/rwsq_ctrl.sv
hw/rtl/rwsq_dp.sv
hw/rtl/range_weighted_square_count_query.sv
verif/tb_top.sv
